[design/buddy_block_allocator_top_assert.svh]
// assertion macros for the buddy allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define BBA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(label, clk, rst_n, prop, msg)
`define BBA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[design/bba_pkg.sv]
// shared types and constants for the buddy allocator
package bba_pkg;
  localparam int unsigned OpW = 1;
  localparam int unsigned LevW = 4;
  localparam int unsigned IdxW = 8;
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StScanChk,
    StUnlinkA,
    StUnlinkB,
    StUnlinkC,
    StSplit,
    StPushA,
    StPushB,
    StPushC,
    StFreeChk,
    StMergeRd,
    StMergeChk,
    StDone
  } state_e;
endpackage

[design/bba_if.sv]
// valid/ready channel with allocator payload fields
interface bba_req_if
  import bba_pkg::*;
();
  logic valid;
  logic ready;
  logic [OpW-1:0] op;
  logic [LevW-1:0] req_level;
  logic [IdxW-1:0] block_index;
  modport source (output valid, op, req_level, block_index, input ready);
  modport sink (input valid, op, req_level, block_index, output ready);
endinterface

interface bba_rsp_if
  import bba_pkg::*;
();
  logic valid;
  logic ready;
  logic ok;
  logic [IdxW-1:0] granted_index;
  logic [LevW-1:0] final_level;
  modport source (output valid, ok, granted_index, final_level, input ready);
  modport sink (input valid, ok, granted_index, final_level, output ready);
endinterface

[design/bba_node_mem.sv]
// node memory: free flag, level and both links per node, registered read
module bba_node_mem #(
  parameter int unsigned AW = 9,
  parameter int unsigned DW = 23
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

[design/buddy_block_allocator_top.sv]
// Buddy allocator over 2^TOP_LEVEL minimum blocks. Free-list nodes (blocks, then one head
// node per level) live in a single node memory with a registered read; every list update is
// a read, then a write of the whole node word. After reset a clearing pass writes every
// node before the first transaction is taken. An allocate scans the lists upward from the
// requested level, unlinks the tail of the first non-empty list and splits it down to the
// requested level, pushing each upper half; a free merges with free buddies level by level
// and then pushes the merged block. One transaction is worked at a time; the result is
// held in an output register until taken and no new request is accepted meanwhile.
module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned TOP_LEVEL = 8
) (
  input logic clk_i,
  input logic rst_ni,
  bba_req_if.sink req_i,
  bba_rsp_if.source rsp_o
);
  `include "buddy_block_allocator_top_assert.svh"

  localparam int unsigned NB = 2**TOP_LEVEL;
  localparam int unsigned AW = TOP_LEVEL + 1;
  localparam int unsigned KW = LevW;
  // node word: free, level, next, prev
  localparam int unsigned DW = 1 + KW + 2*AW;

  typedef struct packed {
    logic          free;
    logic [KW-1:0] lev;
    logic [AW-1:0] nxt;
    logic [AW-1:0] prv;
  } node_t;

  state_e st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] raddr, waddr;
  logic we;
  node_t wnode, rnode;
  logic [DW-1:0] rdata;

  logic op_q, op_d;
  logic [KW-1:0] req_q, req_d, j_q, j_d;
  logic [AW-1:0] blk_q, blk_d, l_q, l_d;
  logic [AW-1:0] a_q, a_d, b_q, b_d, first_q, first_d;
  logic [AW-1:0] psh_q, psh_d;
  logic [KW-1:0] pshlev_q, pshlev_d;
  logic rv_q, rv_d, rok_q, rok_d;
  logic [IdxW-1:0] rgi_q, rgi_d;
  logic [LevW-1:0] rfl_q, rfl_d;

  bba_node_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wnode),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  assign rnode = node_t'(rdata);

  function automatic logic [AW-1:0] head(input logic [KW-1:0] lv);
    return AW'(NB) + AW'(lv);
  endfunction

  // out-of-range link names node zero
  function automatic logic [AW-1:0] nok(input logic [AW-1:0] n);
    return ({1'b0, n} < (AW+1)'(NB + TOP_LEVEL + 1)) ? n : '0;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; req_q <= req_d; j_q <= j_d; blk_q <= blk_d;
    l_q <= l_d; a_q <= a_d; b_q <= b_d; first_q <= first_d;
    psh_q <= psh_d; pshlev_q <= pshlev_d;
    rok_q <= rok_d; rgi_q <= rgi_d; rfl_q <= rfl_d;
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClear:     if (clr_q == AW'(2**AW - 1)) st_d = StIdle;
      StIdle: begin
        if (req_i.valid && !rv_q) begin
          if (req_i.op == OpFree) st_d = StFreeChk;
          else if (req_i.req_level > KW'(TOP_LEVEL)) st_d = StDone;
          else st_d = StScanChk;
        end
      end
      StScanChk: begin
        if (nok(rnode.nxt) != head(j_q)) begin
          st_d = (nok(rnode.prv) < AW'(NB)) ? StUnlinkA : StDone;
        end else if (j_q == KW'(TOP_LEVEL)) begin
          st_d = StDone;
        end
      end
      StUnlinkA:   st_d = StUnlinkB;
      StUnlinkB: begin
        if (a_q != b_q) st_d = StUnlinkC;
        else st_d = (op_q == OpFree) ? StMergeRd : StSplit;
      end
      StUnlinkC:   st_d = (op_q == OpFree) ? StMergeRd : StSplit;
      StSplit:     st_d = (j_q > req_q) ? StPushA : StDone;
      StPushA:     st_d = StPushB;
      StPushB: begin
        if (first_q != head(pshlev_q)) st_d = StPushC;
        else st_d = (op_q == OpFree) ? StDone : StSplit;
      end
      StPushC:     st_d = (op_q == OpFree) ? StDone : StSplit;
      StFreeChk:   st_d = rnode.free ? StDone : StMergeRd;
      StMergeRd:   st_d = (j_q < KW'(TOP_LEVEL)) ? StMergeChk : StPushA;
      StMergeChk: begin
        if (!rnode.free || rnode.lev != j_q) st_d = StPushA;
        else st_d = StUnlinkA;
      end
      StDone:      st_d = StIdle;
      default:     st_d = StIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d = clr_q; op_d = op_q; req_d = req_q; j_d = j_q; blk_d = blk_q;
    l_d = l_q; a_d = a_q; b_d = b_q; first_d = first_q;
    psh_d = psh_q; pshlev_d = pshlev_q;
    rv_d = rv_q; rok_d = rok_q; rgi_d = rgi_q; rfl_d = rfl_q;
    raddr = '0; waddr = '0; we = 1'b0; wnode = '0;
    req_i.ready = 1'b0;
    if (rsp_o.valid && rsp_o.ready) rv_d = 1'b0;
    unique case (st_q)
      StClear: begin
        we = 1'b1; waddr = clr_q; clr_d = clr_q + 1'b1;
        if (clr_q == '0) begin
          wnode = '{free: 1'b1, lev: KW'(TOP_LEVEL),
                    nxt: head(KW'(TOP_LEVEL)), prv: head(KW'(TOP_LEVEL))};
        end else if (clr_q >= AW'(NB) && clr_q < head(KW'(TOP_LEVEL))) begin
          // empty list heads point to themselves
          wnode = '{free: 1'b0, lev: '0, nxt: clr_q, prv: clr_q};
        end
      end
      StIdle: begin
        req_i.ready = !rv_q;
        if (req_i.valid && !rv_q) begin
          op_d = req_i.op; req_d = req_i.req_level; j_d = req_i.req_level;
          l_d = AW'(req_i.block_index & IdxW'(NB - 1));
          rok_d = 1'b0; rgi_d = '0; rfl_d = '0;
          raddr = (req_i.op == OpFree) ? AW'(req_i.block_index & IdxW'(NB - 1))
                                       : head(req_i.req_level);
        end
      end
      StScanChk: begin
        if (nok(rnode.nxt) != head(j_q)) begin
          // take the tail of the first non-empty list
          blk_d = nok(rnode.prv); raddr = nok(rnode.prv);
        end else if (j_q != KW'(TOP_LEVEL)) begin
          j_d = j_q + 1'b1; raddr = head(j_q + 1'b1);
        end
      end
      StUnlinkA: begin
        a_d = nok(rnode.prv); b_d = nok(rnode.nxt);
        we = 1'b1; waddr = blk_q; wnode = rnode; wnode.free = 1'b0;
        if (op_q == OpAlloc) wnode.lev = req_q;
        raddr = nok(rnode.prv);
      end
      StUnlinkB: begin
        we = 1'b1; waddr = a_q; wnode = rnode; wnode.nxt = b_q;
        if (a_q == b_q) wnode.prv = a_q;
        raddr = b_q;
      end
      StUnlinkC: begin
        we = 1'b1; waddr = b_q; wnode = rnode; wnode.prv = a_q;
      end
      StSplit: begin
        if (j_q > req_q) begin
          j_d = j_q - 1'b1;
          psh_d = (blk_q + (AW'(1) << (j_q - 1'b1))) & AW'(NB - 1);
          pshlev_d = j_q - 1'b1;
          raddr = head(j_q - 1'b1);
        end else begin
          rok_d = 1'b1; rgi_d = IdxW'(blk_q); rfl_d = req_q;
        end
      end
      StPushA: begin
        first_d = nok(rnode.nxt);
        we = 1'b1; waddr = psh_q;
        wnode = '{free: 1'b1, lev: pshlev_q, nxt: nok(rnode.nxt),
                  prv: head(pshlev_q)};
        raddr = nok(rnode.nxt);
      end
      StPushB: begin
        // prev of first; an empty list has the head as first
        we = 1'b1; waddr = first_q; wnode = rnode; wnode.prv = psh_q;
        if (first_q == head(pshlev_q)) begin
          wnode.nxt = psh_q;
          if (op_q == OpFree) begin
            rok_d = 1'b1; rfl_d = pshlev_q;
          end
        end else begin
          raddr = head(pshlev_q);
        end
      end
      StPushC: begin
        we = 1'b1; waddr = head(pshlev_q); wnode = rnode; wnode.nxt = psh_q;
        if (op_q == OpFree) begin
          rok_d = 1'b1; rfl_d = pshlev_q;
        end
      end
      StFreeChk: begin
        if (!rnode.free) j_d = (rnode.lev > KW'(TOP_LEVEL)) ? KW'(TOP_LEVEL) : rnode.lev;
      end
      StMergeRd: begin
        if (j_q < KW'(TOP_LEVEL)) begin
          blk_d = (l_q ^ (AW'(1) << j_q)) & AW'(NB - 1);
          raddr = (l_q ^ (AW'(1) << j_q)) & AW'(NB - 1);
        end else begin
          psh_d = l_q; pshlev_d = j_q; raddr = head(j_q);
        end
      end
      StMergeChk: begin
        if (!rnode.free || rnode.lev != j_q) begin
          psh_d = l_q; pshlev_d = j_q; raddr = head(j_q);
        end else begin
          // buddy is free at this level: merge, keep the lower start
          raddr = blk_q;
          if (blk_q < l_q) l_d = blk_q;
          j_d = j_q + 1'b1;
        end
      end
      StDone: rv_d = 1'b1;
      default: ;
    endcase
  end

  assign rsp_o.valid = rv_q;
  assign rsp_o.ok = rok_q;
  assign rsp_o.granted_index = rgi_q;
  assign rsp_o.final_level = rfl_q;

  `BBA_ASSERT(a_no_accept_busy, clk_i, rst_ni, req_i.ready |-> st_q == StIdle, "busy accept")
  `BBA_ASSERT(a_rsp_after_done, clk_i, rst_ni, $rose(rv_q) |-> $past(st_q) == StDone, "bad rsp")
  `BBA_ASSERT(a_no_ready_pend, clk_i, rst_ni, rv_q |-> !req_i.ready, "accept with pending")
  `BBA_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.ok) && $stable(rsp_o.granted_index) && $stable(rsp_o.final_level), "rsp changed while waiting")
endmodule

[verif/tb_buddy_block_allocator_top.sv]
// testbench for the buddy block allocator: directed and random allocate/free traffic
module tb_buddy_block_allocator_top
  import bba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TopLevel = 8;
  localparam int unsigned NumBlk = 1 << TopLevel;
  localparam int unsigned NumNode = NumBlk + TopLevel + 1;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic ok;
    logic [IdxW-1:0] granted_index;
    logic [LevW-1:0] final_level;
  } alloc_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  buddy_block_allocator_top #(.TOP_LEVEL(TopLevel)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(req_if.sink),
    .rsp_o(rsp_if.source)
  );

  always #1 clk_i = ~clk_i;

  // shadow free lists: blocks first, then one head node per level
  bit mdl_free[NumBlk];
  logic [LevW-1:0] mdl_level[NumBlk];
  int unsigned mdl_next[NumNode];
  int unsigned mdl_prev[NumNode];
  alloc_rsp_t rsp_queue[$];
  // blocks the model currently holds as allocated, for well-formed frees
  int unsigned held_idx[$];

  function automatic int unsigned head_of(int unsigned lv);
    return NumBlk + lv;
  endfunction

  function automatic int unsigned clamp_node(int unsigned n);
    return n < NumNode ? n : 0;
  endfunction

  function automatic void lists_unlink(int unsigned n);
    int unsigned a;
    int unsigned b;
    a = clamp_node(mdl_prev[n]);
    b = clamp_node(mdl_next[n]);
    mdl_next[a] = b;
    mdl_prev[b] = a;
  endfunction

  function automatic void lists_push(int unsigned blk, int unsigned lv);
    int unsigned h;
    int unsigned first;
    h = head_of(lv);
    first = clamp_node(mdl_next[h]);
    mdl_next[blk] = first;
    mdl_prev[blk] = h;
    mdl_prev[first] = blk;
    mdl_next[h] = blk;
    mdl_free[blk] = 1'b1;
    mdl_level[blk] = LevW'(lv);
  endfunction

  function automatic void arena_reset();
    for (int i = 0; i < NumBlk; i++) begin
      mdl_free[i] = 1'b0;
      mdl_level[i] = '0;
      mdl_next[i] = 0;
      mdl_prev[i] = 0;
    end
    for (int i = 0; i <= TopLevel; i++) begin
      mdl_next[head_of(i)] = head_of(i);
      mdl_prev[head_of(i)] = head_of(i);
    end
    lists_push(0, TopLevel);
  endfunction

  function automatic alloc_rsp_t arena_apply(logic op, logic [LevW-1:0] lvl,
                                             logic [IdxW-1:0] bidx);
    alloc_rsp_t r;
    int unsigned j;
    int unsigned blk;
    int unsigned k;
    int unsigned l;
    int unsigned p;
    int unsigned idx;
    r = '0;
    idx = bidx & (NumBlk - 1);
    if (op == OpAlloc) begin
      if (lvl <= TopLevel) begin
        j = lvl;
        while (j <= TopLevel && clamp_node(mdl_next[head_of(j)]) == head_of(j)) j++;
        if (j <= TopLevel) begin
          blk = clamp_node(mdl_prev[head_of(j)]);
          if (blk < NumBlk) begin
            lists_unlink(blk);
            mdl_free[blk] = 1'b0;
            while (j > lvl) begin
              j--;
              lists_push((blk + (1 << j)) & (NumBlk - 1), j);
            end
            mdl_level[blk] = lvl;
            r.ok = 1'b1;
            r.granted_index = IdxW'(blk);
            r.final_level = lvl;
            held_idx.push_back(blk);
          end
        end
      end
    end else if (!mdl_free[idx]) begin
      k = mdl_level[idx];
      l = idx;
      if (k > TopLevel) k = TopLevel;
      while (k < TopLevel) begin
        p = (l ^ (1 << k)) & (NumBlk - 1);
        if (!mdl_free[p] || mdl_level[p] != k) break;
        lists_unlink(p);
        mdl_free[p] = 1'b0;
        if (p < l) l = p;
        k++;
      end
      lists_push(l, k);
      r.ok = 1'b1;
      r.final_level = LevW'(k);
    end
    return r;
  endfunction

  function automatic bit want_idle();
    return !calm && ($urandom_range(99) < 14);
  endfunction

  initial begin
    req_if.valid = 1'b0;
    req_if.op = OpAlloc;
    req_if.req_level = '0;
    req_if.block_index = '0;
    rsp_if.ready = 1'b0;
  end

  // receiver: random stalls, check against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: unexpected result ok=%0d idx=%0d lvl=%0d", $realtime,
                   rsp_if.ok, rsp_if.granted_index, rsp_if.final_level);
          errors++;
        end else begin
          alloc_rsp_t e;
          e = rsp_queue.pop_front();
          if (rsp_if.ok !== e.ok) begin
            $display("%0t: ok expected %0d actual %0d", $realtime, e.ok, rsp_if.ok);
            errors++;
          end
          if (rsp_if.granted_index !== e.granted_index) begin
            $display("%0t: granted_index expected %0d actual %0d", $realtime,
                     e.granted_index, rsp_if.granted_index);
            errors++;
          end
          if (rsp_if.final_level !== e.final_level) begin
            $display("%0t: final_level expected %0d actual %0d", $realtime,
                     e.final_level, rsp_if.final_level);
            errors++;
          end
        end
      end
      rsp_if.ready <= !want_idle();
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("** buddy_block_allocator_top: FAILED **");
      $finish;
    end
  end

  // valid stays high after the transaction until the next idle or item
  task automatic send_item(logic op, logic [LevW-1:0] lvl, logic [IdxW-1:0] bidx);
    while (want_idle()) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.req_level <= lvl;
    req_if.block_index <= bidx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    rsp_queue.push_back(arena_apply(op, lvl, bidx));
    if (op == OpFree) begin
      for (int i = 0; i < held_idx.size(); i++)
        if (held_idx[i] == (bidx & (NumBlk - 1))) begin
          held_idx.delete(i);
          break;
        end
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic free_random_held();
    int unsigned i;
    int unsigned b;
    i = $urandom_range(held_idx.size() - 1);
    b = held_idx[i];
    send_item(OpFree, LevW'($urandom), IdxW'(b));
  endtask

  task automatic test_directed();
    send_item(OpAlloc, LevW'(TopLevel), 8'd0);  // whole arena
    send_item(OpAlloc, 4'd0, 8'd0);             // all levels empty
    send_item(OpFree, 4'hf, 8'h00);       // free merges nothing, back to top
    send_item(OpFree, 4'd0, 8'h00);       // free of a block already free
    send_item(OpAlloc, 4'd9, 8'hff);      // level above top
    send_item(OpAlloc, 4'hf, 8'h00);
    send_item(OpAlloc, 4'd0, 8'hff);      // full split to level 0
    send_item(OpAlloc, 4'd0, 8'd0);
    send_item(OpAlloc, 4'd3, 8'd0);
    send_item(OpAlloc, 4'd7, 8'd0);
    send_item(OpFree, 4'd0, 8'd1);
    send_item(OpFree, 4'd0, 8'd0);        // merges with its buddy
    send_item(OpFree, 4'd0, 8'hff);       // not an allocated block start
    send_item(OpFree, 4'd0, 8'd128);
    drain();
    // pause until all results are back, then free everything still held
    while (held_idx.size() != 0) free_random_held();
    send_item(OpFree, 4'd0, 8'h55);
    send_item(OpFree, 4'd0, 8'haa);
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 500; n++) begin
      calm = (n >= 200 && n < 280);
      if (n == 350) drain();
      if ($urandom_range(99) < 8) begin
        send_item(1'($urandom), LevW'($urandom), IdxW'($urandom));   // noise
      end else if (held_idx.size() != 0 && $urandom_range(1)) begin
        free_random_held();
      end else begin
        send_item(OpAlloc, LevW'($urandom_range(99) < 80 ? $urandom_range(3)
                                                         : $urandom_range(TopLevel)),
                  IdxW'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    arena_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && rsp_queue.size() == 0) begin
      $display("** buddy_block_allocator_top: PASSED **");
    end else begin
      $display("** buddy_block_allocator_top: FAILED **");
    end
    $finish;
  end
endmodule

[buddy_block_allocator_top.f]
+incdir+design
design/bba_pkg.sv
design/bba_if.sv
design/bba_node_mem.sv
design/buddy_block_allocator_top.sv
verif/tb_buddy_block_allocator_top.sv
